### hdl/bmc_pkg.sv
// Package with shared constants, types and helper functions of the batched MAC check.
`default_nettype none
package bmc_pkg;
    localparam int CountWidth = 32;
    localparam int TwN = 312;
    localparam int TwM = 156;
    localparam int TwAddrWidth = 9;
    localparam logic [63:0] TwMatrix = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TwInitMult = 64'd6364136223846793005;
    localparam logic [36:0] TrafficMax = 37'h1F_FFFF_FFFF;

    localparam logic [1:0] RegKeyZero = 2'd0;
    localparam logic [1:0] RegKeyOne = 2'd1;
    localparam logic [1:0] RegRingBits = 2'd2;
    localparam logic [1:0] RegSeed = 2'd3;

    typedef logic [63:0] word_t;

    // Output tempering of the 64-bit twister.
    function automatic word_t temper(input word_t w_in);
        word_t w;
        w = w_in;
        w = w ^ ((w >> 29) & 64'h5555_5555_5555_5555);
        w = w ^ ((w << 17) & 64'h71D6_7FFF_EDA6_0000);
        w = w ^ ((w << 37) & 64'hFFF7_EEE0_0000_0000);
        w = w ^ (w >> 43);
        return w;
    endfunction

    // Mask of the ring for a raw width code; 0 acts as 1, above 64 as 64.
    function automatic word_t ring_mask(input logic [6:0] bits);
        word_t m;
        m = '1;
        if (bits == 7'd0)
        begin
            m = 64'd1;
        end
        else if (bits < 7'd64)
        begin
            m = (64'd1 << bits[5:0]) - 64'd1;
        end
        return m;
    endfunction
endpackage
`default_nettype wire

### hdl/bmc_if.sv
// Interfaces of the item, result and configuration channels.
`default_nettype none
interface bmc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_share_a;
    logic [63:0] mac_share_a;
    logic [63:0] value_share_b;
    logic [63:0] mac_share_b;
    logic        last_item;
    modport source (output valid, value_share_a, mac_share_a, value_share_b, mac_share_b,
                    last_item, input ready);
    modport sink (input valid, value_share_a, mac_share_a, value_share_b, mac_share_b,
                  last_item, output ready);
endinterface

interface bmc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] opened_value;
    logic        batch_done;
    logic        batch_accepted;
    logic [36:0] traffic_bytes;
    modport source (output valid, opened_value, batch_done, batch_accepted, traffic_bytes,
                    input ready);
    modport sink (input valid, opened_value, batch_done, batch_accepted, traffic_bytes,
                  output ready);
endinterface

interface bmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/bmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bmc_ram #(
    parameter int Width = 64,
    parameter int Depth = 312
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/batched_mac_check_core.sv
// Top level of the batched MAC check: sequencer, twister store and shared multiplier.
`default_nettype none
// A result is offered once its accepted input transaction has gone through three
// twister word reads through the single read port of the state RAM, a twist, two
// passes through one shared 32x32 multiplier that builds 64-bit products (delta*x,
// then r*(tag-delta*x)), and an output step. The next transaction can be accepted on
// the cycle after the output step, so a batch runs one transaction at a time. The
// first transaction of a batch first seeds the 312-word twister, one word per
// multiplier pass, before its twister reads. A result that is not taken stays in the
// output register while the next transaction is worked on. That transaction then
// waits in its output step, and the input stays blocked until the consumer takes the
// waiting result. Opened values are returned for every transaction. The last one of a
// batch also carries the accept flag and the traffic count.
module batched_mac_check_core (
    input wire logic clk,
    input wire logic rst_n,
    bmc_in_if.sink   in_ch,
    bmc_out_if.source out_ch,
    bmc_cfg_if.sink  cfg
);
    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StSeed = 4'd1;
    localparam logic [3:0] StRd0 = 4'd2;
    localparam logic [3:0] StRd1 = 4'd3;
    localparam logic [3:0] StRd2 = 4'd4;
    localparam logic [3:0] StTwist = 4'd5;
    localparam logic [3:0] StMul = 4'd6;
    localparam logic [3:0] StOut = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [63:0] key0_reg, key1_reg, seed_reg;
    logic [6:0]  bits_reg;
    logic        open_reg;
    logic [8:0]  tidx_reg;
    logic [63:0] acc_reg;
    logic [bmc_pkg::CountWidth-1:0] cnt_reg;
    logic [63:0] x_reg, tag_reg, w0_reg, w1_reg, r_reg, prev_reg;
    logic [63:0] pa_reg, pb_reg, mres_reg;
    logic [1:0]  mstep_reg;
    logic        mpass_reg;
    logic        last_reg;
    logic [8:0]  sidx_reg;
    logic        ovalid_reg;
    logic [63:0] oval_reg;
    logic        odone_reg, oacc_reg;
    logic [36:0] otraf_reg;

    logic [63:0] mask;
    logic        we;
    logic [8:0]  waddr, raddr;
    logic [63:0] wdata, rdata;
    logic [63:0] y, tw;
    logic [31:0] ma, mb;
    logic [63:0] pp;
    logic [8:0]  i1, im;
    logic [63:0] seed_prev;
    logic [6:0]  ring_width;
    logic [4:0]  per;
    logic [bmc_pkg::CountWidth-1:0] cnt_inc;
    logic [bmc_pkg::CountWidth:0] n1;
    logic [bmc_pkg::CountWidth+4:0] traf_full;
    logic        out_free;

    assign mask = bmc_pkg::ring_mask(bits_reg);
    assign cfg.ready = (state_reg == StIdle) && !ovalid_reg && !in_ch.valid;
    assign in_ch.ready = (state_reg == StIdle);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.opened_value = oval_reg;
    assign out_ch.batch_done = odone_reg;
    assign out_ch.batch_accepted = oacc_reg;
    assign out_ch.traffic_bytes = otraf_reg;

    // The output register can take a new result when empty or being emptied.
    assign out_free = !ovalid_reg || out_ch.ready;

    // Neighbour addresses of the twist, wrapped at the store depth.
    assign i1 = (tidx_reg == 9'(bmc_pkg::TwN - 1)) ? 9'd0 : tidx_reg + 9'd1;
    assign im = (tidx_reg >= 9'(bmc_pkg::TwN - bmc_pkg::TwM)) ?
                tidx_reg - 9'(bmc_pkg::TwN - bmc_pkg::TwM) : tidx_reg + 9'(bmc_pkg::TwM);

    // Twist of one word from the three values read.
    assign y = {w0_reg[63:31], w1_reg[30:0]};
    assign tw = rdata ^ (y >> 1) ^ (y[0] ? bmc_pkg::TwMatrix : 64'd0);

    // Shared 32x32 multiplier; steps produce lo*lo, lo*hi, hi*lo for a 64-bit product.
    always_comb
    begin
        case (mstep_reg)
            2'd0:
            begin
                ma = pa_reg[31:0];
                mb = pb_reg[31:0];
            end
            2'd1:
            begin
                ma = pa_reg[31:0];
                mb = pb_reg[63:32];
            end
            default:
            begin
                ma = pa_reg[63:32];
                mb = pb_reg[31:0];
            end
        endcase
        pp = 64'(ma) * 64'(mb);
    end

    assign seed_prev = prev_reg ^ (prev_reg >> 62);

    // RAM port control.
    always_comb
    begin
        we = 1'b0;
        waddr = sidx_reg;
        wdata = mres_reg + 64'(sidx_reg);
        raddr = tidx_reg;
        case (state_reg)
            StSeed:
            begin
                we = (mstep_reg == 2'd3);
                waddr = sidx_reg;
                wdata = (sidx_reg == 9'd0) ? seed_reg : mres_reg + 64'(sidx_reg);
            end
            StRd0: raddr = tidx_reg;
            StRd1: raddr = i1;
            StRd2: raddr = im;
            StTwist:
            begin
                we = 1'b1;
                waddr = tidx_reg;
                wdata = tw;
            end
            default: raddr = tidx_reg;
        endcase
    end

    bmc_ram #(.Width(64), .Depth(bmc_pkg::TwN)) u_tw_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Item count after this transaction, saturating at its width.
    assign cnt_inc = (cnt_reg == '1) ? cnt_reg :
                     cnt_reg + {{(bmc_pkg::CountWidth - 1){1'b0}}, 1'b1};

    // Traffic count for the closing transaction.
    assign ring_width = (bits_reg == 7'd0) ? 7'd1 : ((bits_reg > 7'd64) ? 7'd64 : bits_reg);
    assign per = {4'(({1'b0, ring_width} + 8'd7) >> 3), 1'b0};
    assign n1 = {1'b0, cnt_inc} + {{bmc_pkg::CountWidth{1'b0}}, 1'b1};
    assign traf_full = (bmc_pkg::CountWidth + 5)'(n1) * (bmc_pkg::CountWidth + 5)'(per);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            StIdle:
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = open_reg ? StRd0 : StSeed;
                end
            StSeed:
                if (mstep_reg == 2'd3 && sidx_reg == 9'(bmc_pkg::TwN - 1))
                begin
                    state_next = StRd0;
                end
            StRd0: state_next = StRd1;
            StRd1: state_next = StRd2;
            StRd2: state_next = StTwist;
            StTwist: state_next = StMul;
            StMul:
                if (mstep_reg == 2'd3 && mpass_reg)
                begin
                    state_next = StOut;
                end
            StOut:
                if (out_free)
                begin
                    state_next = StIdle;
                end
            default: state_next = StIdle;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            key0_reg <= '0;
            key1_reg <= '0;
            seed_reg <= '0;
            bits_reg <= 7'd64;
            open_reg <= 1'b0;
            tidx_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            mstep_reg <= '0;
            mpass_reg <= 1'b0;
            sidx_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    bmc_pkg::RegKeyZero: key0_reg <= cfg.data;
                    bmc_pkg::RegKeyOne: key1_reg <= cfg.data;
                    bmc_pkg::RegRingBits: bits_reg <= cfg.data[6:0];
                    bmc_pkg::RegSeed: seed_reg <= cfg.data;
                    default: seed_reg <= seed_reg;
                endcase
            end
            // A new result is loaded as the previous one leaves or after it has left.
            if (state_reg == StOut && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                StIdle:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        mpass_reg <= 1'b0;
                        sidx_reg <= '0;
                        if (!open_reg)
                        begin
                            open_reg <= 1'b1;
                            tidx_reg <= '0;
                            acc_reg <= '0;
                            cnt_reg <= '0;
                            mstep_reg <= 2'd3;
                        end
                        else
                        begin
                            mstep_reg <= 2'd0;
                        end
                    end
                StSeed:
                begin
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3)
                    begin
                        sidx_reg <= sidx_reg + 9'd1;
                    end
                end
                StTwist: mstep_reg <= 2'd0;
                StMul:
                begin
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3)
                    begin
                        mpass_reg <= 1'b1;
                    end
                end
                StOut:
                    if (out_free)
                    begin
                        tidx_reg <= i1;
                        acc_reg <= (acc_reg + mres_reg) & mask;
                        cnt_reg <= cnt_inc;
                        if (last_reg)
                        begin
                            open_reg <= 1'b0;
                        end
                    end
                default: mstep_reg <= mstep_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            StIdle:
                if (in_ch.valid && in_ch.ready)
                begin
                    x_reg <= (in_ch.value_share_a + in_ch.value_share_b) & mask;
                    tag_reg <= (in_ch.mac_share_a + in_ch.mac_share_b) & mask;
                    last_reg <= in_ch.last_item;
                    pa_reg <= (key0_reg + key1_reg) & mask;
                    pb_reg <= (in_ch.value_share_a + in_ch.value_share_b) & mask;
                    prev_reg <= seed_reg;
                    mres_reg <= '0;
                end
            StSeed:
            begin
                // Steps 0..2 accumulate the product, step 3 writes and reloads.
                if (mstep_reg == 2'd3)
                begin
                    if (sidx_reg != 9'd0)
                    begin
                        prev_reg <= mres_reg + 64'(sidx_reg);
                        pa_reg <= bmc_pkg::TwInitMult;
                        pb_reg <= (mres_reg + 64'(sidx_reg)) ^
                                  ((mres_reg + 64'(sidx_reg)) >> 62);
                    end
                    else
                    begin
                        pa_reg <= bmc_pkg::TwInitMult;
                        pb_reg <= seed_prev;
                    end
                    mres_reg <= '0;
                end
                else if (mstep_reg == 2'd0)
                begin
                    mres_reg <= pp;
                end
                else
                begin
                    mres_reg <= mres_reg + {pp[31:0], 32'd0};
                end
            end
            StRd1: w0_reg <= rdata;
            StRd2: w1_reg <= rdata;
            StTwist:
            begin
                r_reg <= bmc_pkg::temper(tw) & mask;
                pa_reg <= (key0_reg + key1_reg) & mask;
                pb_reg <= x_reg;
                mres_reg <= '0;
            end
            StMul:
            begin
                if (mstep_reg == 2'd0)
                begin
                    mres_reg <= pp;
                end
                else if (mstep_reg != 2'd3)
                begin
                    mres_reg <= mres_reg + {pp[31:0], 32'd0};
                end
                else if (!mpass_reg)
                begin
                    pa_reg <= r_reg;
                    pb_reg <= tag_reg - mres_reg;
                end
            end
            StOut:
                if (out_free)
                begin
                    oval_reg <= x_reg;
                    odone_reg <= last_reg;
                    oacc_reg <= last_reg && (((acc_reg + mres_reg) & mask) == 64'd0);
                    if (!last_reg)
                    begin
                        otraf_reg <= '0;
                    end
                    else if (traf_full > (bmc_pkg::CountWidth + 5)'(bmc_pkg::TrafficMax))
                    begin
                        otraf_reg <= bmc_pkg::TrafficMax;
                    end
                    else
                    begin
                        otraf_reg <= 37'(traf_full);
                    end
                end
            default: mres_reg <= mres_reg;
        endcase
    end

    // The result register holds while the consumer stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.opened_value))
        else $error("result dropped while stalled");
    // No transaction is taken while work is in progress.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != StIdle |-> !in_ch.ready)
        else $error("ready while busy");
    // Accept is only reported with the closing result.
    a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.batch_accepted |-> out_ch.batch_done)
        else $error("accept without batch end");
endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking testbench of the batched MAC check core with its own twister predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    typedef struct {
        logic [63:0] opened;
        logic        done;
        logic        accepted;
        logic [36:0] traffic;
    } opening_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_index;
        logic [63:0] reg_data;
        logic [63:0] va;
        logic [63:0] ma;
        logic [63:0] vb;
        logic [63:0] mb;
        logic        last;
        logic        typed;
        opening_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bmc_in_if  in_ch ();
    bmc_out_if out_ch ();
    bmc_cfg_if cfg ();

    batched_mac_check_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Predictor copy of the registers and of the batch state.
    logic [63:0] key_zero;
    logic [63:0] key_one;
    logic [6:0]  ring_code;
    logic [63:0] seed_word;
    logic [63:0] mt_words [bmc_pkg::TwN];
    int          mt_pos;
    logic [63:0] check_sum;
    longint      item_count;
    logic        in_batch;

    opening_t    pending_openings[$];
    stim_row_t   directed_rows[$];
    int          mismatches;
    int          items_sent;
    int          send_idle_pct;
    int          recv_idle_pct;

    // Clock and the single reset at the start.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog on the whole run.
    initial
    begin
        #50ms;
        $display("batched_mac_check_core verification failed");
        $finish;
    end

    function automatic int ring_width();
        if (ring_code == 7'd0)
        begin
            return 1;
        end
        if (ring_code > 7'd64)
        begin
            return 64;
        end
        return int'(ring_code);
    endfunction

    function automatic logic [63:0] width_mask(int w);
        if (w >= 64)
        begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    // Next twister word: twist the current slot in place, then temper it.
    function automatic logic [63:0] next_random();
        logic [63:0] y;
        logic [63:0] w;
        int          i;
        i = (mt_pos >= bmc_pkg::TwN) ? 0 : mt_pos;
        y = (mt_words[i] & 64'hFFFF_FFFF_8000_0000)
            | (mt_words[(i + 1) % bmc_pkg::TwN] & 64'h0000_0000_7FFF_FFFF);
        w = mt_words[(i + bmc_pkg::TwM) % bmc_pkg::TwN] ^ (y >> 1)
            ^ (y[0] ? bmc_pkg::TwMatrix : 64'd0);
        mt_words[i] = w;
        mt_pos = (i + 1) % bmc_pkg::TwN;
        w = w ^ ((w >> 29) & 64'h5555_5555_5555_5555);
        w = w ^ ((w << 17) & 64'h71D6_7FFF_EDA6_0000);
        w = w ^ ((w << 37) & 64'hFFF7_EEE0_0000_0000);
        w = w ^ (w >> 43);
        return w;
    endfunction

    // Opens one share pair and folds its MAC into the batch check.
    function automatic opening_t open_and_fold(logic [63:0] va, logic [63:0] ma,
                                               logic [63:0] vb, logic [63:0] mb,
                                               logic last);
        opening_t    o;
        int          w;
        logic [63:0] m;
        logic [63:0] delta;
        logic [63:0] x;
        logic [63:0] tag;
        logic [63:0] r;
        logic [63:0] diff;
        longint      per;
        longint      total;
        w = ring_width();
        m = width_mask(w);
        delta = (key_zero + key_one) & m;
        x = (va + vb) & m;
        tag = (ma + mb) & m;
        if (!in_batch)
        begin
            mt_words[0] = seed_word;
            for (int i = 1; i < bmc_pkg::TwN; i++)
            begin
                mt_words[i] = bmc_pkg::TwInitMult
                              * (mt_words[i - 1] ^ (mt_words[i - 1] >> 62)) + 64'(i);
            end
            mt_pos = 0;
            check_sum = '0;
            item_count = 0;
            in_batch = 1'b1;
        end
        r = next_random() & m;
        diff = tag - delta * x;
        check_sum = (check_sum + r * diff) & m;
        if (item_count < 64'hFFFF_FFFF)
        begin
            item_count++;
        end
        o.opened = x;
        o.done = 1'b0;
        o.accepted = 1'b0;
        o.traffic = '0;
        if (last)
        begin
            per = 2 * ((w + 7) / 8);
            total = per * (item_count + 1);
            o.done = 1'b1;
            o.accepted = (check_sum == 64'd0);
            o.traffic = (total > longint'(bmc_pkg::TrafficMax)) ? bmc_pkg::TrafficMax
                                                                : 37'(total);
            in_batch = 1'b0;
        end
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        opening_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_openings.size() == 0)
            begin
                report_mismatch("unexpected result", out_ch.opened_value, 64'd0);
            end
            else
            begin
                e = pending_openings.pop_front();
                if (out_ch.opened_value !== e.opened)
                    report_mismatch("opened_value", out_ch.opened_value, e.opened);
                if (out_ch.batch_done !== e.done)
                    report_mismatch("batch_done", 64'(out_ch.batch_done), 64'(e.done));
                if (out_ch.batch_accepted !== e.accepted)
                    report_mismatch("batch_accepted", 64'(out_ch.batch_accepted),
                                    64'(e.accepted));
                if (out_ch.traffic_bytes !== e.traffic)
                    report_mismatch("traffic_bytes", 64'(out_ch.traffic_bytes),
                                    64'(e.traffic));
            end
        end
    end

    // Result side back-pressure, with one long hold-off part way through.
    initial
    begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (items_sent >= 350 && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Idle pattern follows progress through the stimulus.
    always @(negedge clk)
    begin
        if (items_sent < 250)
        begin
            send_idle_pct = 12;
            recv_idle_pct = 81;
        end
        else if (items_sent < 500)
        begin
            send_idle_pct = 81;
            recv_idle_pct = 12;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    task automatic wait_drained();
        while (pending_openings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // Register write; only called once the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        case (idx)
            bmc_pkg::RegKeyZero:  key_zero = data;
            bmc_pkg::RegKeyOne:   key_one = data;
            bmc_pkg::RegRingBits: ring_code = data[6:0];
            bmc_pkg::RegSeed:     seed_word = data;
            default:              ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Offers one item, with a random gap first; prediction is made at acceptance.
    task automatic send_item(logic [63:0] va, logic [63:0] ma, logic [63:0] vb,
                             logic [63:0] mb, logic last, logic typed, opening_t want);
        opening_t o;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.value_share_a <= va;
        in_ch.mac_share_a <= ma;
        in_ch.value_share_b <= vb;
        in_ch.mac_share_b <= mb;
        in_ch.last_item <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        o = open_and_fold(va, ma, vb, mb, last);
        if (typed)
        begin
            o = want;
        end
        pending_openings = {pending_openings, o};
        items_sent++;
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void add_item(logic [63:0] va, logic [63:0] ma, logic [63:0] vb,
                                     logic [63:0] mb, logic last, logic typed,
                                     logic [63:0] op, logic acc, logic [36:0] tr);
        stim_row_t r;
        r.kind = ROW_ITEM;
        r.reg_index = bmc_pkg::RegKeyZero;
        r.reg_data = '0;
        r.va = va;
        r.ma = ma;
        r.vb = vb;
        r.mb = mb;
        r.last = last;
        r.typed = typed;
        r.want.opened = op;
        r.want.done = last;
        r.want.accepted = acc;
        r.want.traffic = tr;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [63:0] data);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.reg_index = idx;
        r.reg_data = data;
        r.va = '0;
        r.ma = '0;
        r.vb = '0;
        r.mb = '0;
        r.last = 1'b0;
        r.typed = 1'b0;
        r.want.opened = '0;
        r.want.done = 1'b0;
        r.want.accepted = 1'b0;
        r.want.traffic = '0;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic logic [6:0] pick_ring();
        logic [6:0] picks [10] = '{7'd0, 7'd1, 7'd2, 7'd7, 7'd8, 7'd9, 7'd63, 7'd64,
                                   7'd65, 7'd127};
        if ($urandom_range(3) == 0)
        begin
            return 7'($urandom_range(1, 64));
        end
        return picks[$urandom_range(9)];
    endfunction

    // Main stimulus: directed table, then random batches.
    initial
    begin
        opening_t    none;
        logic [63:0] m;
        logic [63:0] delta;
        logic [63:0] x;
        logic [63:0] tag;
        logic [63:0] va;
        logic [63:0] ma;
        int          n;
        int          mode;
        int          bad_at;
        int          batch_no;
        int          w;
        int          guard;

        none = '{default: '0};
        mismatches = 0;
        items_sent = 0;
        send_idle_pct = 12;
        recv_idle_pct = 81;
        key_zero = '0;
        key_one = '0;
        ring_code = 7'd64;
        seed_word = '0;
        mt_pos = 0;
        check_sum = '0;
        item_count = 0;
        in_batch = 1'b0;
        for (int i = 0; i < bmc_pkg::TwN; i++)
        begin
            mt_words[i] = '0;
        end
        in_ch.valid = 1'b0;
        in_ch.value_share_a = '0;
        in_ch.mac_share_a = '0;
        in_ch.value_share_b = '0;
        in_ch.mac_share_b = '0;
        in_ch.last_item = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = bmc_pkg::RegKeyZero;
        cfg.data = '0;

        // After reset the key is zero, so zero tags always pass.
        add_item('1, '0, 64'd1, '0, 1'b1, 1'b1, 64'd0, 1'b1, 37'd32);
        add_item('0, '0, '0, '0, 1'b0, 1'b1, 64'd0, 1'b0, 37'd0);
        add_item('1, '1, '1, '1, 1'b1, 1'b0, '0, 1'b0, '0);
        // Key shares that cancel, all-ones seed, three-item batch.
        add_cfg(bmc_pkg::RegKeyZero, '1);
        add_cfg(bmc_pkg::RegKeyOne, 64'd1);
        add_cfg(bmc_pkg::RegSeed, '1);
        add_item(64'd5, 64'd0, 64'd7, 64'd0, 1'b0, 1'b0, '0, 1'b0, '0);
        add_item('1, 64'd3, '0, 64'd9, 1'b0, 1'b0, '0, 1'b0, '0);
        add_item(64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000, 64'd0, 1'b1,
                 1'b0, '0, 1'b0, '0);
        // Zero ring width acts as one bit; delta is zero there.
        add_cfg(bmc_pkg::RegRingBits, 64'd0);
        add_item(64'd1, 64'd0, 64'd0, 64'd0, 1'b1, 1'b1, 64'd1, 1'b1, 37'd4);
        // Width code above 64 acts as 64.
        add_cfg(bmc_pkg::RegRingBits, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(64'd10, 64'd0, 64'd20, 64'd0, 1'b1, 1'b1, 64'd30, 1'b1, 37'd32);
        // Narrow rings and a zero seed with a real key.
        add_cfg(bmc_pkg::RegRingBits, 64'd1);
        add_cfg(bmc_pkg::RegSeed, 64'd0);
        add_cfg(bmc_pkg::RegKeyZero, 64'd3);
        add_cfg(bmc_pkg::RegKeyOne, 64'd0);
        add_item('1, '1, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0);
        add_item(64'd1, 64'd1, 64'd0, 64'd0, 1'b1, 1'b0, '0, 1'b0, '0);
        add_cfg(bmc_pkg::RegRingBits, 64'd8);
        add_item(64'h1FF, 64'h123, 64'h2, 64'h77, 1'b0, 1'b0, '0, 1'b0, '0);
        add_item(64'hFF, 64'hFD, 64'h0, 64'h0, 1'b1, 1'b0, '0, 1'b0, '0);

        @(posedge rst_n);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else
            begin
                send_item(directed_rows[i].va, directed_rows[i].ma, directed_rows[i].vb,
                          directed_rows[i].mb, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random batches: mostly correctly tagged, some with one bit flipped, some noise.
        batch_no = 0;
        while (items_sent < 700)
        begin
            if (batch_no % 6 == 0 || $urandom_range(7) == 0)
            begin
                wait_drained();
                write_reg(bmc_pkg::RegKeyZero, ($urandom_range(9) == 0) ? '1 : rand64());
                write_reg(bmc_pkg::RegKeyOne, ($urandom_range(9) == 0) ? '0 : rand64());
                write_reg(bmc_pkg::RegRingBits, {57'(rand64() >> 7), pick_ring()});
                write_reg(bmc_pkg::RegSeed, ($urandom_range(9) == 0) ? '0 : rand64());
            end
            if (batch_no == 8)
            begin
                wait_drained();
            end
            n = ($urandom_range(19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
            mode = $urandom_range(99);
            bad_at = (mode >= 60 && mode < 75) ? $urandom_range(n - 1) : -1;
            w = ring_width();
            m = width_mask(w);
            delta = key_zero + key_one;
            for (int k = 0; k < n; k++)
            begin
                if (mode >= 75)
                begin
                    send_item(rand64(), rand64(), rand64(), rand64(), k == n - 1, 1'b0, none);
                end
                else
                begin
                    x = rand64();
                    tag = delta * x;
                    if (k == bad_at)
                    begin
                        tag = tag ^ (64'd1 << $urandom_range(w - 1));
                    end
                    va = rand64();
                    ma = rand64();
                    send_item(va, ma, x - va, tag - ma, k == n - 1, 1'b0, none);
                end
            end
            batch_no++;
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        // Drain, with a limit, then settle.
        guard = 0;
        while (pending_openings.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_openings.size() == 0)
        begin
            $display("batched_mac_check_core verification clean");
        end
        else
        begin
            $display("batched_mac_check_core verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
